FILE: rtl/cpc_pkg.sv
// shared constants, payload types and stage records of the cross peak clip filter
`default_nettype none

package cpc_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int PIXEL_BITS     = 16;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int FW_BITS        = 11;
    localparam int FH_BITS        = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int PAIR_BITS      = 2 * PIXEL_BITS;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [COL_BITS-1:0]   col_t;
    typedef logic [FH_BITS-1:0]    row_t;

    typedef enum logic {
        PATH_LAGGED,
        PATH_FLUSH
    } path_t;

    typedef struct packed {
        logic   kind;
        pixel_t pixel_in;
    } in_item_t;

    typedef struct packed {
        pixel_t pixel_out;
        logic   end_of_row;
        logic   end_of_frame;
    } out_item_t;

    typedef struct packed {
        logic                      valid;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } cfg_wr_t;

    // one column of both line buffers
    typedef struct packed {
        pixel_t older;
        pixel_t newer;
    } line_pair_t;

    typedef struct packed {
        col_t left_addr;
        col_t mid_addr;
        col_t right_addr;
        col_t cur_addr;
    } rd_addr_t;

    typedef struct packed {
        logic       we;
        col_t       addr;
        line_pair_t data;
    } wr_port_t;

    // decision record handed from the sequencer to the window stage
    typedef struct packed {
        logic   emit;
        logic   write;
        path_t  path;
        col_t   out_col;
        col_t   in_col;
        pixel_t pixel;
        logic   up_en;
        logic   left_en;
        logic   right_en;
        logic   down_en;
        logic   eor;
        logic   eof;
    } stage_req_t;

endpackage

`default_nettype wire

FILE: rtl/cpc_ram.sv
// generic line memory: one write port, two registered read ports
`default_nettype none

module cpc_ram #(
    parameter int  DEPTH     = 1024,
    parameter int  WIDTH     = 32,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr_a,
    output logic      [WIDTH-1:0]     rdata_a,
    input  wire logic [ADDR_BITS-1:0] raddr_b,
    output logic      [WIDTH-1:0]     rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // read returns the contents before a write at the same edge
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

FILE: rtl/cpc_seq.sv
// sequencer: configuration registers, raster counters, memory addresses
`default_nettype none

module cpc_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cpc_pkg::cfg_wr_t    cfg_wr,
    input  wire logic                accept,
    input  wire cpc_pkg::in_item_t   item,
    output cpc_pkg::rd_addr_t        rd_addr,
    output logic                     req_valid_reg,
    output cpc_pkg::stage_req_t      req_reg
);

    import cpc_pkg::*;

    localparam int ROW_EXT = FH_BITS + 1;

    logic [FW_BITS-1:0] frame_width_reg, frame_width_next;
    logic [FH_BITS-1:0] frame_height_reg, frame_height_next;
    col_t               in_col_reg, in_col_next;
    col_t               out_col_reg, out_col_next;
    row_t               in_row_reg, in_row_next;
    row_t               out_row_reg, out_row_next;
    logic [FW_BITS-1:0] pending_reg, pending_next;
    logic               req_valid_next;
    stage_req_t         req_next;

    logic [FW_BITS-1:0] w_eff;
    logic [FW_BITS-1:0] full;
    logic [FH_BITS-1:0] h_eff;
    logic               in_col_last, in_row_last, out_col_last, out_row_last;
    logic               is_full, flush_ok, emit;

    always_comb begin
        w_eff = frame_width_reg;
        if (frame_width_reg == '0) begin
            w_eff = FW_BITS'(1);
        end else if (frame_width_reg > FW_BITS'(MAX_WIDTH)) begin
            w_eff = FW_BITS'(MAX_WIDTH);
        end
        h_eff = (frame_height_reg == '0) ? FH_BITS'(1) : frame_height_reg;
        full  = w_eff + FW_BITS'(1);

        in_col_last  = (FW_BITS'(in_col_reg) + FW_BITS'(1)) >= w_eff;
        out_col_last = (FW_BITS'(out_col_reg) + FW_BITS'(1)) >= w_eff;
        in_row_last  = (ROW_EXT'(in_row_reg) + ROW_EXT'(1)) >= ROW_EXT'(h_eff);
        out_row_last = (ROW_EXT'(out_row_reg) + ROW_EXT'(1)) >= ROW_EXT'(h_eff);

        is_full  = pending_reg >= full;
        flush_ok = (pending_reg != '0) && (in_col_reg == '0) && (in_row_reg == '0);
        emit     = (item.kind == KIND_PIXEL) ? is_full : flush_ok;

        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        pending_next      = pending_reg;

        if (cfg_wr.valid) begin
            case (cfg_wr.index)
                CFG_FRAME_WIDTH: begin
                    frame_width_next = cfg_wr.data[FW_BITS-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    frame_height_next = cfg_wr.data[FH_BITS-1:0];
                end
                default: begin
                end
            endcase
        end

        if (accept) begin
            if (item.kind == KIND_PIXEL) begin
                if (in_col_last) begin
                    in_col_next = '0;
                    in_row_next = in_row_last ? '0 : in_row_reg + FH_BITS'(1);
                end else begin
                    in_col_next = in_col_reg + COL_BITS'(1);
                end
                pending_next = is_full ? full : pending_reg + FW_BITS'(1);
            end else if (flush_ok) begin
                pending_next = is_full ? w_eff : pending_reg - FW_BITS'(1);
            end
            if (emit) begin
                if (out_col_last) begin
                    out_col_next = '0;
                    out_row_next = out_row_last ? '0 : out_row_reg + FH_BITS'(1);
                end else begin
                    out_col_next = out_col_reg + COL_BITS'(1);
                end
            end
        end

        req_valid_next    = accept;
        req_next.emit     = emit;
        req_next.write    = (item.kind == KIND_PIXEL);
        req_next.path     = (item.kind == KIND_FLUSH && !is_full) ? PATH_FLUSH : PATH_LAGGED;
        req_next.out_col  = out_col_reg;
        req_next.in_col   = in_col_reg;
        req_next.pixel    = item.pixel_in;
        req_next.up_en    = (out_row_reg != '0);
        req_next.left_en  = (out_col_reg != '0);
        req_next.right_en = !out_col_last;
        req_next.down_en  = !out_row_last;
        req_next.eor      = out_col_last;
        req_next.eof      = out_col_last && out_row_last;

        rd_addr.left_addr  = out_col_reg - COL_BITS'(1);
        rd_addr.mid_addr   = out_col_reg;
        rd_addr.right_addr = out_col_reg + COL_BITS'(1);
        rd_addr.cur_addr   = in_col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_BITS'(MAX_WIDTH);
            frame_height_reg <= FH_BITS'(1);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            pending_reg      <= '0;
            req_valid_reg    <= 1'b0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            pending_reg      <= pending_next;
            req_valid_reg    <= req_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

endmodule

`default_nettype wire

FILE: rtl/cpc_win.sv
// window stage: write forwarding, neighbour select, peak clip, line writeback
`default_nettype none

module cpc_win (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 req_valid,
    input  wire cpc_pkg::stage_req_t  req,
    input  wire cpc_pkg::line_pair_t  rd_left,
    input  wire cpc_pkg::line_pair_t  rd_mid,
    input  wire cpc_pkg::line_pair_t  rd_right,
    input  wire cpc_pkg::line_pair_t  rd_cur,
    output cpc_pkg::wr_port_t         wr,
    output logic                      res_valid,
    output cpc_pkg::out_item_t        res
);

    import cpc_pkg::*;

    logic       fwd_valid_reg, fwd_valid_next;
    col_t       fwd_addr_reg, fwd_addr_next;
    line_pair_t fwd_data_reg, fwd_data_next;
    pixel_t     window_up_reg, window_up_next;

    col_t       left_addr, right_addr;
    line_pair_t left_p, mid_p, right_p, cur_p;
    pixel_t     up_v, left_v, right_v, down_v, center_v;
    pixel_t     up_m, left_m, right_m, down_m;
    pixel_t     max_a, max_b, max_all;
    logic       any_en;

    always_comb begin
        left_addr  = req.out_col - COL_BITS'(1);
        right_addr = req.out_col + COL_BITS'(1);

        // the write of the previous item lands at the edge these reads were taken
        left_p  = (fwd_valid_reg && fwd_addr_reg == left_addr) ? fwd_data_reg : rd_left;
        mid_p   = (fwd_valid_reg && fwd_addr_reg == req.out_col) ? fwd_data_reg : rd_mid;
        right_p = (fwd_valid_reg && fwd_addr_reg == right_addr) ? fwd_data_reg : rd_right;
        cur_p   = (fwd_valid_reg && fwd_addr_reg == req.in_col) ? fwd_data_reg : rd_cur;

        if (req.path == PATH_FLUSH) begin
            // last row of the frame sits in the newer line
            up_v     = mid_p.older;
            left_v   = left_p.newer;
            center_v = mid_p.newer;
            down_v   = '0;
        end else begin
            up_v     = window_up_reg;
            left_v   = left_p.older;
            center_v = mid_p.older;
            down_v   = mid_p.newer;
        end
        right_v = right_p.newer;

        up_m    = req.up_en    ? up_v    : '0;
        left_m  = req.left_en  ? left_v  : '0;
        right_m = req.right_en ? right_v : '0;
        down_m  = req.down_en  ? down_v  : '0;
        max_a   = (up_m > left_m) ? up_m : left_m;
        max_b   = (right_m > down_m) ? right_m : down_m;
        max_all = (max_a > max_b) ? max_a : max_b;
        any_en  = req.up_en || req.left_en || req.right_en || req.down_en;

        res_valid        = req_valid && req.emit;
        res.pixel_out    = (any_en && center_v > max_all) ? max_all : center_v;
        res.end_of_row   = req.eor;
        res.end_of_frame = req.eof;

        wr.we         = req_valid && req.write;
        wr.addr       = req.in_col;
        wr.data.older = cur_p.newer;
        wr.data.newer = req.pixel;

        window_up_next = window_up_reg;
        if (req_valid) begin
            if (req.write) begin
                window_up_next = cur_p.older;
            end else if (req.emit && req.path == PATH_FLUSH) begin
                window_up_next = mid_p.older;
            end
        end

        fwd_valid_next = wr.we;
        fwd_addr_next  = wr.addr;
        fwd_data_next  = wr.data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
            window_up_reg <= '0;
        end else begin
            fwd_valid_reg <= fwd_valid_next;
            window_up_reg <= window_up_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/cpc_outq.sv
// three-entry result queue with space look-ahead for the input side
`default_nettype none

module cpc_outq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire cpc_pkg::out_item_t  push_data,
    input  wire logic                inflight,
    output logic                     space_ok,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cpc_pkg::out_item_t       m_data
);

    import cpc_pkg::*;

    localparam int DEPTH    = 3;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    out_item_t             q_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  pop;

    always_comb begin
        pop         = m_valid && m_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        count_next = count_reg + CNT_BITS'(push) - CNT_BITS'(pop);
        // an item in the window stage still needs a slot
        space_ok = ((CNT_BITS + 1)'(count_reg) + (CNT_BITS + 1)'(inflight))
                   < (CNT_BITS + 1)'(DEPTH);
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cross_peak_clip_filter.sv
// top level of the cross peak clip filter
`default_nettype none

// Four-neighbour peak clipping over a raster stream: a pixel strictly above every in-frame
// up, down, left and right neighbour is replaced by the largest of them, all others pass
// unchanged. Results trail the input by one row plus one pixel; once the last pixel of a
// frame is in, flush items (kind 1) drain the pixels still held, up to width + 1 of them,
// one per transfer, and a flush taken anywhere but at the start of a frame, or with nothing
// pending, gives no result. The block takes one item per clock while s_ready is high; each
// item does a single read-modify-write pass over the line memories, read in the cycle it
// is accepted and written back in the cycle after, with the previous write forwarded. A
// result goes from the window stage into a three-entry result queue; s_ready counts the
// result still in the window stage against the queue, so a stall on the m_ side drops
// s_ready once the queued results plus the one in the window stage reach three. The line
// memories are not cleared at reset: there is no warm-up pass, and a frame only reads
// entries it has written itself. frame_width and frame_height are written through the cfg_
// channel (always ready); the user must write them only while no transfer is in flight;
// the block does not enforce it. Width 0 acts as 1, above 1024 as 1024, height 0 as 1.

module cross_peak_clip_filter (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire cpc_pkg::in_item_t                     s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output cpc_pkg::out_item_t                         m_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [cpc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [cpc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    import cpc_pkg::*;

    cfg_wr_t    cfg_wr;
    logic       accept;
    rd_addr_t   rd_addr;
    logic       req_valid;
    stage_req_t req;
    line_pair_t rd_left, rd_mid, rd_right, rd_cur;
    wr_port_t   wr;
    logic       res_valid;
    out_item_t  res;
    logic       space_ok;

    // configuration writes never stall
    assign cfg_ready     = 1'b1;
    assign cfg_wr.valid  = cfg_valid;
    assign cfg_wr.index  = cfg_index;
    assign cfg_wr.data   = cfg_data;

    // input transfer
    assign s_ready = space_ok;
    assign accept  = s_valid && s_ready;

    // counters and addresses, registered decision record
    cpc_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr        (cfg_wr),
        .accept        (accept),
        .item          (s_data),
        .rd_addr       (rd_addr),
        .req_valid_reg (req_valid),
        .req_reg       (req)
    );

    // two copies of the {older, newer} line pair, written alike, four read ports in all
    cpc_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PAIR_BITS)
    ) u_ram_out (
        .aclk    (aclk),
        .we      (wr.we),
        .waddr   (wr.addr),
        .wdata   (wr.data),
        .raddr_a (rd_addr.left_addr),
        .rdata_a (rd_left),
        .raddr_b (rd_addr.mid_addr),
        .rdata_b (rd_mid)
    );

    cpc_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PAIR_BITS)
    ) u_ram_in (
        .aclk    (aclk),
        .we      (wr.we),
        .waddr   (wr.addr),
        .wdata   (wr.data),
        .raddr_a (rd_addr.right_addr),
        .rdata_a (rd_right),
        .raddr_b (rd_addr.cur_addr),
        .rdata_b (rd_cur)
    );

    // neighbour window, clip decision and line writeback
    cpc_win u_win (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req       (req),
        .rd_left   (rd_left),
        .rd_mid    (rd_mid),
        .rd_right  (rd_right),
        .rd_cur    (rd_cur),
        .wr        (wr),
        .res_valid (res_valid),
        .res       (res)
    );

    // result queue, counts the result still in the window stage
    cpc_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .inflight  (res_valid),
        .space_ok  (space_ok),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
